@@ hw/rtl/iam_pkg.sv @@
package iam_pkg;

    localparam int ADDR_BITS  = 14;
    localparam int WORD_BITS  = 16;
    localparam int DEPTH      = 1 << ADDR_BITS;
    localparam int OFFSET_BITS = 11;

    localparam logic [OFFSET_BITS-1:0] AUTO_LOW  = OFFSET_BITS'(8);   // 010 octal
    localparam logic [OFFSET_BITS-1:0] AUTO_HIGH = OFFSET_BITS'(15);  // 017 octal

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    typedef logic [ADDR_BITS-1:0] t_addr;
    typedef logic [WORD_BITS-1:0] t_word;

    typedef struct packed {
        logic  en;
        logic  we;
        t_addr addr;
        t_word wdata;
    } t_mem_req;

    // Offset within the 2K-word block falls in the auto-index window.
    function automatic logic is_auto_index(input t_addr a);
        logic [OFFSET_BITS-1:0] off;
        off = a[OFFSET_BITS-1:0];
        return (off >= AUTO_LOW) && (off <= AUTO_HIGH);
    endfunction

endpackage

@@ hw/rtl/iam_store.sv @@
module iam_store
    import iam_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_word    o_rdata
);

    t_word r_mem [DEPTH];
    t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            if (i_req.we) begin
                r_mem[i_req.addr] <= i_req.wdata;
            end else begin
                r_rdata <= r_mem[i_req.addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/indirect_autoindex_memory_core.sv @@
// Channel   Direction  Signals                                          Handshake
// request   in         i_mode, i_address, i_indirect, i_write_value     start & !busy
// result    out        o_read_data                                      o_read_valid strobe
//
// A direct access makes one store access. An indirect access reads the pointer
// cell, writes back the incremented pointer if auto-index, then accesses the
// target. The word store has a single port serving one read or one write per cycle.
// Read data appears in the cycle after the final read is issued, for one cycle.
// Reset: a clearing pass writes zero to all 16384 words, one per cycle;
// busy stays high after reset until the pass is done.
// The receiver cannot stall: a result is shown once and never held.
module indirect_autoindex_memory_core
    import iam_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_mode,
    input  logic [15:0]          i_address,
    input  logic                 i_indirect,
    input  logic [WORD_BITS-1:0] i_write_value,
    output logic [WORD_BITS-1:0] o_read_data,
    output logic                 o_read_valid
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_PTR,
        S_FINAL
    } t_state;

    t_state   r_state,    n_state;
    t_addr    r_clr_addr, n_clr_addr;
    logic     r_mode,     n_mode;
    logic     r_auto,     n_auto;
    t_word    r_value,    n_value;
    t_addr    r_ea,       n_ea;
    logic     r_valid,    n_valid;

    t_mem_req mem_req;
    t_word    mem_rdata;
    t_addr    in_addr;
    t_word    ptr_inc;

    iam_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    // Drop address bits above the store size.
    assign in_addr = i_address[ADDR_BITS-1:0];
    assign ptr_inc = mem_rdata + WORD_BITS'(1);

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_mode     = r_mode;
        n_auto     = r_auto;
        n_value    = r_value;
        n_ea       = r_ea;
        n_valid    = 1'b0;
        mem_req    = '{en: 1'b0, we: 1'b0, addr: '0, wdata: '0};

        unique case (r_state)
            S_CLEAR: begin
                // Sweep the store with zeros, one word per cycle.
                mem_req    = '{en: 1'b1, we: 1'b1, addr: r_clr_addr, wdata: '0};
                n_clr_addr = r_clr_addr + ADDR_BITS'(1);
                if (r_clr_addr == {ADDR_BITS{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_mode  = i_mode;
                    n_value = i_write_value;
                    n_auto  = is_auto_index(in_addr);
                    n_ea    = in_addr;
                    mem_req = '{en: 1'b1, we: 1'b0, addr: in_addr, wdata: '0};
                    if (i_indirect) begin
                        // Fetch the pointer cell first.
                        n_state = S_PTR;
                    end else if (i_mode == MODE_WRITE) begin
                        mem_req.we    = 1'b1;
                        mem_req.wdata = i_write_value;
                    end else begin
                        n_valid = 1'b1;
                    end
                end
            end
            S_PTR: begin
                if (r_auto) begin
                    // Write back the incremented pointer; the next access
                    // sees it, so a target equal to the cell reads the new word.
                    mem_req = '{en: 1'b1, we: 1'b1, addr: r_ea, wdata: ptr_inc};
                    n_ea    = ptr_inc[ADDR_BITS-1:0];
                    n_state = S_FINAL;
                end else begin
                    mem_req = '{en: 1'b1, we: r_mode == MODE_WRITE,
                                addr: mem_rdata[ADDR_BITS-1:0], wdata: r_value};
                    n_valid = (r_mode == MODE_READ);
                    n_state = S_IDLE;
                end
            end
            S_FINAL: begin
                mem_req = '{en: 1'b1, we: r_mode == MODE_WRITE,
                            addr: r_ea, wdata: r_value};
                n_valid = (r_mode == MODE_READ);
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_valid    <= n_valid;
        end
        r_mode  <= n_mode;
        r_auto  <= n_auto;
        r_value <= n_value;
        r_ea    <= n_ea;
    end

    // Hold busy through the clearing pass and multi-cycle accesses.
    assign busy         = (r_state != S_IDLE);
    assign o_read_valid = r_valid;
    assign o_read_data  = mem_rdata;

endmodule

@@ tb/sv/tb_indirect_autoindex_memory_core.sv @@
module tb_indirect_autoindex_memory_core
    import iam_pkg::*;
();

    // Quiet cycles tolerated before the run is called hung. The clearing pass
    // after reset keeps busy high until all words are cleared; leave ample room.
    localparam int STALL_LIMIT = 4 * DEPTH + 8000;
    localparam int RANDOM_REQUESTS = 1800;
    // Cycles to wait after the last read returns, as slack before the run ends.
    localparam int DRAIN_CYCLES = 8;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_mode = MODE_READ;
    logic [15:0]          i_address = '0;
    logic                 i_indirect = 1'b0;
    logic [WORD_BITS-1:0] i_write_value = '0;
    logic [WORD_BITS-1:0] o_read_data;
    logic                 o_read_valid;

    // Shadow copy of the word store, cleared like the block's store at reset.
    t_word word_image [DEPTH];
    // Words that accepted reads must return, oldest first.
    t_word pending_reads [$];

    int unsigned error_count = 0;
    // Set during stretches where the sender never idles.
    bit back_to_back = 1'b0;

    indirect_autoindex_memory_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_mode        (i_mode),
        .i_address     (i_address),
        .i_indirect    (i_indirect),
        .i_write_value (i_write_value),
        .o_read_data   (o_read_data),
        .o_read_valid  (o_read_valid)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Update the shadow store for one accepted request and queue the word a
    // read must return. The pointer cell is bumped first on auto-index, so a
    // pointer that lands on its own cell sees the incremented word.
    function automatic void apply_access(input logic mode, input logic [15:0] address,
                                         input logic ind, input t_word wval);
        t_addr                  ptr_cell;
        t_addr                  target;
        logic [OFFSET_BITS-1:0] offset;
        ptr_cell = address[ADDR_BITS-1:0];
        target   = ptr_cell;
        if (ind) begin
            offset = ptr_cell[OFFSET_BITS-1:0];
            if (offset >= AUTO_LOW && offset <= AUTO_HIGH) begin
                word_image[ptr_cell] = word_image[ptr_cell] + WORD_BITS'(1);
            end
            // Drop pointer bits above the address width.
            target = word_image[ptr_cell][ADDR_BITS-1:0];
        end
        if (mode == MODE_WRITE) begin
            word_image[target] = wval;
        end else begin
            pending_reads.push_back(word_image[target]);
        end
    endfunction

    // Mostly short gaps, a few long ones, none in back-to-back stretches.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (back_to_back || roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Issue one request and hold it through a clock edge and until busy reads
    // low. Start stays high from one request to the next when there is no gap,
    // so it is never lowered and raised in the same step.
    task automatic issue_request(input logic mode, input logic [15:0] address,
                                 input logic ind, input t_word wval);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_mode        <= mode;
        i_address     <= address;
        i_indirect    <= ind;
        i_write_value <= wval;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        apply_access(mode, address, ind, wval);
    endtask

    // Plain reads and writes at the ends of the address range, with address
    // bits above the store width, and a direct hit on an auto-index cell.
    task automatic test_direct_access();
        issue_request(MODE_WRITE, 16'h0000, 1'b0, 16'hffff);
        issue_request(MODE_READ,  16'h0000, 1'b0, 16'h1234);
        issue_request(MODE_WRITE, 16'hffff, 1'b0, 16'h8001);
        issue_request(MODE_READ,  16'h3fff, 1'b0, 16'h0000);
        issue_request(MODE_READ,  16'hc000, 1'b0, 16'hffff);
        // Direct access to an auto-index cell must not bump it.
        issue_request(MODE_WRITE, 16'o10,   1'b0, 16'h5555);
        issue_request(MODE_READ,  16'o10,   1'b0, 16'h0000);
    endtask

    // Indirect access through an ordinary cell, with high bits set both in
    // the pointer word and in the request address.
    task automatic test_indirect_access();
        issue_request(MODE_WRITE, 16'h0100, 1'b0, 16'hc200);
        issue_request(MODE_WRITE, 16'h0100, 1'b1, 16'haaaa);
        issue_request(MODE_READ,  16'h0200, 1'b0, 16'h0000);
        issue_request(MODE_READ,  16'h4100, 1'b1, 16'h0000);
    endtask

    // Auto-index window edges, a window in a higher block, pointer wrap past
    // all ones, and pointers that land on their own cell.
    task automatic test_auto_index();
        issue_request(MODE_WRITE, 16'o17,    1'b0, 16'h01ff);
        issue_request(MODE_READ,  16'o17,    1'b1, 16'h0000);
        issue_request(MODE_WRITE, 16'o17,    1'b1, 16'h1357);
        issue_request(MODE_READ,  16'o17,    1'b0, 16'h0000);
        issue_request(MODE_WRITE, 16'o04010, 1'b0, 16'hffff);
        issue_request(MODE_READ,  16'o04010, 1'b1, 16'h0000);
        // Just below the window: plain indirect, no bump.
        issue_request(MODE_WRITE, 16'o7,     1'b0, 16'h0200);
        issue_request(MODE_READ,  16'o7,     1'b1, 16'h0000);
        // Read through a cell that points at itself after the bump.
        issue_request(MODE_WRITE, 16'o11,    1'b0, 16'o10);
        issue_request(MODE_READ,  16'o11,    1'b1, 16'h0000);
        // Write through a cell that points at itself after the bump.
        issue_request(MODE_WRITE, 16'o12,    1'b0, 16'hc009);
        issue_request(MODE_WRITE, 16'o12,    1'b1, 16'h7777);
        issue_request(MODE_READ,  16'o12,    1'b0, 16'h0000);
    endtask

    // Addresses cluster on auto-index cells and a small data pool so that
    // pointers get reused and bumped; the rest is spread over all 16 bits.
    function automatic logic [15:0] pick_address();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 3) begin
            return {2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                    11'($urandom_range(6, 17))};
        end
        if (roll < 7) begin
            return {2'($urandom_range(0, 3)), 14'(14'h0200 + $urandom_range(0, 31))};
        end
        return 16'($urandom);
    endfunction

    // Half the write data looks like a pointer into the hot regions; the
    // rest is any word, including the values that wrap on a bump.
    function automatic t_word pick_word();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 5) return pick_address();
        if (roll == 5) return 16'hffff;
        return 16'($urandom);
    endfunction

    task automatic test_random_traffic();
        logic mode;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 150 == 0) back_to_back = ($urandom_range(0, 3) == 0);
            mode = $urandom_range(0, 1) ? MODE_WRITE : MODE_READ;
            issue_request(mode, pick_address(), 1'($urandom_range(0, 1)), pick_word());
        end
        back_to_back = 1'b0;
    endtask

    // Check every read strobe against the oldest expected word.
    always @(posedge i_clk) begin : check_reads
        t_word want;
        if (i_rst_n && o_read_valid === 1'b1) begin
            if (pending_reads.size() == 0) begin
                $error("unexpected read result: read_data actual %h", o_read_data);
                error_count++;
            end else begin
                want = pending_reads.pop_front();
                if (o_read_data !== want) begin
                    $error("read_data mismatch: expected %h actual %h", want, o_read_data);
                    error_count++;
                end
            end
        end
    end

    // End the run when nothing moves for too long.
    initial begin : watchdog
        int unsigned quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((start && busy === 1'b0) || o_read_valid === 1'b1) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb_indirect_autoindex_memory_core: done, errors");
        $finish;
    end

    initial begin
        for (int a = 0; a < DEPTH; a++) word_image[a] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_direct_access();
        test_indirect_access();
        test_auto_index();
        test_random_traffic();

        // Drop start once busy reads low after the last request, then drain
        // the outstanding reads.
        start <= 1'b0;
        while (pending_reads.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("tb_indirect_autoindex_memory_core: done, clean");
        end else begin
            $display("tb_indirect_autoindex_memory_core: done, errors");
        end
        $finish;
    end

endmodule
